@@ hw/rtl/rfe_pkg.sv @@
// Package for the remote frame encoder: sizes, command nibbles and the
// payload and frame builder functions.
// No dependencies.
package rfe_pkg;

	// Word, frame and buffer sizes in chips
	localparam int WORD_W     = 64;
	localparam int FIRST_LEN  = 213;
	localparam int NEXT_LEN   = 225;
	localparam int BUF_W      = 288;
	localparam int CNT_W      = 9;
	localparam int PAY_W      = 56;
	localparam int MAN_W      = 112;
	localparam int GAP_LEN    = 48;
	localparam int CHIPS_W    = 7;
	localparam int DEF_NUM_FRAMES = 10;

	// Command codes
	localparam logic [1:0] CMD_OFF  = 2'd0;
	localparam logic [1:0] CMD_ON   = 2'd1;
	localparam logic [1:0] CMD_PROG = 2'd2;
	localparam logic [1:0] CMD_MY   = 2'd3;

	// Nibbles sent for each command
	localparam logic [3:0] NIB_OFF  = 4'h4;
	localparam logic [3:0] NIB_ON   = 4'h2;
	localparam logic [3:0] NIB_PROG = 4'h8;
	localparam logic [3:0] NIB_MY   = 4'h1;

	// Pulse patterns
	localparam logic [7:0] START_PULSE = 8'hF0;
	localparam logic [7:0] SYNC_HIGH   = 8'hFF;

	// Seven chained payload bytes, byte 0 in the top bits
	function automatic logic [PAY_W-1:0] build_payload(input logic [7:0] key,
			input logic [23:0] addr, input logic [1:0] cmd, input logic [15:0] roll);
		logic [6:0][7:0] b;
		logic [3:0] nib;
		logic [3:0] sum;
		case (cmd)
			CMD_OFF:  nib = NIB_OFF;
			CMD_ON:   nib = NIB_ON;
			CMD_PROG: nib = NIB_PROG;
			CMD_MY:   nib = NIB_MY;
			default:  nib = NIB_OFF;
		endcase
		b[0] = key;
		b[1] = {nib, 4'h0};
		b[2] = roll[15:8];
		b[3] = roll[7:0];
		b[4] = addr[7:0];
		b[5] = addr[15:8];
		b[6] = addr[23:16];
		// checksum over all nibbles
		sum = 4'h0;
		for (int i = 0; i < 7; i++) begin
			sum = sum ^ b[i][7:4] ^ b[i][3:0];
		end
		b[1][3:0] = sum;
		// chain each byte with the one before it
		for (int i = 1; i < 7; i++) begin
			b[i] = b[i] ^ b[i-1];
		end
		return {b[0], b[1], b[2], b[3], b[4], b[5], b[6]};
	endfunction

	// Manchester code, a one is low then high
	function automatic logic [MAN_W-1:0] manchester(input logic [PAY_W-1:0] p);
		logic [MAN_W-1:0] m;
		for (int i = 0; i < PAY_W; i++) begin
			m[2*i+1] = ~p[i];
			m[2*i]   = p[i];
		end
		return m;
	endfunction

	// First frame: wake-up high and low, two starting pulses, left aligned
	function automatic logic [BUF_W-1:0] frame_first(input logic [PAY_W-1:0] p);
		return {16'hFFFF, 12'h000, {2{START_PULSE}}, SYNC_HIGH, 1'b0, manchester(p),
			{GAP_LEN{1'b0}}, {(BUF_W-FIRST_LEN){1'b0}}};
	endfunction

	// Repeat frame: seven starting pulses, left aligned
	function automatic logic [BUF_W-1:0] frame_next(input logic [PAY_W-1:0] p);
		return {{7{START_PULSE}}, SYNC_HIGH, 1'b0, manchester(p),
			{GAP_LEN{1'b0}}, {(BUF_W-NEXT_LEN){1'b0}}};
	endfunction

endpackage

@@ hw/rtl/rfe_front.sv @@
// Front end: accepts a request, builds the chained payload and holds it
// in one register until the queue takes it. Uses rfe_pkg.
module rfe_front import rfe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           remote_key,
	input  logic [23:0]          device_address,
	input  logic [1:0]           command,
	input  logic [15:0]          roll_code,
	output logic                 push,
	output logic [PAY_W-1:0]     push_data,
	input  logic                 q_ready
);

	logic             valid_s1;
	logic [PAY_W-1:0] payload_s1;
	logic             accept;

	// stall only while the stage is full and the queue cannot take it
	assign in_stall  = valid_s1 && !q_ready;
	assign accept    = in_valid && !in_stall;
	assign push      = valid_s1 && q_ready;
	assign push_data = payload_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload build
	always_ff @(posedge clk) begin
		if (accept) begin
			payload_s1 <= build_payload(remote_key, device_address, command, roll_code);
		end
	end

endmodule

@@ hw/rtl/rfe_queue.sv @@
// Two-entry queue of payloads between the front and back ends.
// Uses rfe_pkg.
module rfe_queue import rfe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [PAY_W-1:0] push_data,
	output logic             q_ready,
	input  logic             pop,
	output logic             head_valid,
	output logic [PAY_W-1:0] head_data
);

	logic [PAY_W-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign q_ready    = (count_q != 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_data  = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ hw/rtl/rfe_back.sv @@
// Back end: turns one payload into the chip stream, 64 chips a word,
// through a chip buffer that is refilled a whole frame at a time. Uses rfe_pkg.
module rfe_back import rfe_pkg::*; #(
	parameter int NUM_FRAMES = DEF_NUM_FRAMES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  logic [PAY_W-1:0]    head_data,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [WORD_W-1:0]   stream_word,
	output logic [CHIPS_W-1:0]  valid_chips,
	output logic                last_word
);

	localparam int FL_W = $clog2(NUM_FRAMES + 1);

	logic                active_q;
	logic [BUF_W-1:0]    buf_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [FL_W-1:0]     frames_left_q;
	logic [PAY_W-1:0]    pay_q;
	logic                out_valid_q;
	logic [WORD_W-1:0]   word_q;
	logic [CHIPS_W-1:0]  chips_q;
	logic                last_q;

	logic                step;
	logic                is_last;
	logic [CNT_W-1:0]    rem;
	logic                refill;

	assign out_valid   = out_valid_q;
	assign stream_word = word_q;
	assign valid_chips = chips_q;
	assign last_word   = last_q;

	// word issue and next-payload load
	assign step    = active_q && (!out_valid_q || !out_stall);
	assign is_last = (frames_left_q == '0) && (cnt_q <= CNT_W'(WORD_W));
	assign pop     = head_valid && (!active_q || (step && is_last));
	assign rem     = cnt_q - CNT_W'(WORD_W);
	assign refill  = (rem < CNT_W'(WORD_W)) && (frames_left_q != '0);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			cnt_q         <= '0;
			frames_left_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				active_q      <= 1'b1;
				cnt_q         <= CNT_W'(FIRST_LEN);
				frames_left_q <= FL_W'(NUM_FRAMES - 1);
			end else if (step) begin
				if (is_last) begin
					active_q <= 1'b0;
				end else if (refill) begin
					cnt_q         <= rem + CNT_W'(NEXT_LEN);
					frames_left_q <= frames_left_q - FL_W'(1);
				end else begin
					cnt_q <= rem;
				end
			end
		end
	end

	// chip buffer and output word
	always_ff @(posedge clk) begin
		if (step) begin
			word_q  <= buf_q[BUF_W-1 -: WORD_W];
			chips_q <= (cnt_q >= CNT_W'(WORD_W)) ? CHIPS_W'(WORD_W) : cnt_q[CHIPS_W-1:0];
			last_q  <= is_last;
		end
		if (pop) begin
			buf_q <= frame_first(head_data);
			pay_q <= head_data;
		end else if (step && !is_last) begin
			if (refill) begin
				buf_q <= (buf_q << WORD_W) | (frame_next(pay_q) >> rem[5:0]);
			end else begin
				buf_q <= buf_q << WORD_W;
			end
		end
	end

endmodule

@@ hw/rtl/rts_remote_frame_encoder_core.sv @@
// Remote frame encoder top level. A request passes the front, queue and back-end
// load before its first word is presented. Throughput: one 64-chip word a cycle
// while out_stall is low, ceil((213 + (NUM_FRAMES-1)*225)/64) words a request
// (35 at NUM_FRAMES 10), set by the back-end chip buffer; a queued request
// follows the last word with no gap. Reset clears all control state; the queue
// and output are empty after reset. Uses rfe_pkg, rfe_front, rfe_queue, rfe_back.
module rts_remote_frame_encoder_core import rfe_pkg::*; #(
	parameter int NUM_FRAMES = DEF_NUM_FRAMES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          remote_key,
	input  logic [23:0]         device_address,
	input  logic [1:0]          command,
	input  logic [15:0]         roll_code,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [63:0]         stream_word,
	output logic [6:0]          valid_chips,
	output logic                last_word
);

	logic             push;
	logic [PAY_W-1:0] push_data;
	logic             q_ready;
	logic             pop;
	logic             head_valid;
	logic [PAY_W-1:0] head_data;

	// request intake and payload build
	rfe_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.remote_key     (remote_key),
		.device_address (device_address),
		.command        (command),
		.roll_code      (roll_code),
		.push           (push),
		.push_data      (push_data),
		.q_ready        (q_ready)
	);

	// decoupling queue
	rfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.q_ready    (q_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	// chip stream generator
	rfe_back #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_data   (head_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.stream_word (stream_word),
		.valid_chips (valid_chips),
		.last_word   (last_word)
	);

endmodule

@@ test/rfe_stream_checker.sv @@
// Checker for the remote frame encoder: watches both channels, predicts the chip
// stream of every accepted request and compares each output word against it.
// Depends on rfe_pkg for the command codes, the nibbles and the default frame count.
`timescale 1ns / 100ps

module rfe_stream_checker import rfe_pkg::*; #(
	parameter int NUM_FRAMES = DEF_NUM_FRAMES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  remote_key,
	input  logic [23:0] device_address,
	input  logic [1:0]  command,
	input  logic [15:0] roll_code,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] stream_word,
	input  logic [6:0]  valid_chips,
	input  logic        last_word,
	output int          fail_count,
	output int          pending_words,
	output int          words_checked
);

	typedef struct packed {
		logic [63:0] chips;
		logic [6:0]  count;
		logic        last;
	} chip_word_t;

	chip_word_t  expected_words[$];
	logic [63:0] acc_chips;
	int          acc_fill;
	int          mismatches;
	int          checked;

	assign fail_count    = mismatches;
	assign words_checked = checked;

	// Seven bytes with checksum nibble, each chained with the one before it
	function automatic logic [55:0] chain_payload(input logic [7:0] key,
			input logic [23:0] addr, input logic [1:0] cmd, input logic [15:0] roll);
		logic [7:0] pb [7];
		logic [3:0] nib;
		logic [3:0] csum;
		logic [55:0] packed_bytes;
		case (cmd)
			CMD_OFF:  nib = NIB_OFF;
			CMD_ON:   nib = NIB_ON;
			CMD_PROG: nib = NIB_PROG;
			default:  nib = NIB_MY;
		endcase
		pb[0] = key;
		pb[1] = {nib, 4'h0};
		pb[2] = roll[15:8];
		pb[3] = roll[7:0];
		pb[4] = addr[7:0];
		pb[5] = addr[15:8];
		pb[6] = addr[23:16];
		csum = 4'h0;
		for (int i = 0; i < 7; i++)
			csum = csum ^ pb[i][7:4] ^ pb[i][3:0];
		pb[1][3:0] = csum;
		for (int i = 1; i < 7; i++)
			pb[i] = pb[i] ^ pb[i-1];
		packed_bytes = '0;
		for (int i = 0; i < 7; i++)
			packed_bytes = {packed_bytes[47:0], pb[i]};
		return packed_bytes;
	endfunction

	task automatic flush_word(input logic is_last);
		expected_words.push_back('{chips: acc_chips, count: acc_fill[6:0], last: is_last});
		acc_chips = '0;
		acc_fill  = 0;
	endtask

	// Append a run of equal chips, opening a new word when the current one is full
	task automatic put_chips(input logic level, input int len);
		for (int k = 0; k < len; k++) begin
			if (acc_fill >= 64)
				flush_word(1'b0);
			acc_chips[63 - acc_fill] = level;
			acc_fill++;
		end
	endtask

	// Whole transmission: wake-up on the first frame, start and sync pulses,
	// Manchester payload (one = low, high), inter-frame gap
	task automatic predict_transmission(input logic [55:0] payload);
		int starts;
		acc_chips = '0;
		acc_fill  = 0;
		for (int f = 0; f < NUM_FRAMES; f++) begin
			if (f == 0) begin
				put_chips(1'b1, 16);
				put_chips(1'b0, 12);
				starts = 2;
			end else begin
				starts = 7;
			end
			for (int s = 0; s < starts; s++) begin
				put_chips(1'b1, 4);
				put_chips(1'b0, 4);
			end
			put_chips(1'b1, 8);
			put_chips(1'b0, 1);
			for (int i = 55; i >= 0; i--) begin
				put_chips(~payload[i], 1);
				put_chips(payload[i], 1);
			end
			put_chips(1'b0, 48);
		end
		if (acc_fill > 0)
			flush_word(1'b1);
	endtask

	// Predict on each accepted request, compare each accepted word
	always @(posedge clk or negedge arst_n) begin
		chip_word_t exp_word;
		if (!arst_n) begin
			expected_words.delete();
			mismatches    = 0;
			checked       = 0;
			pending_words = 0;
		end else begin
			if (in_valid && !in_stall)
				predict_transmission(chain_payload(remote_key, device_address, command,
					roll_code));
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word: stream_word %h valid_chips %0d last_word %b",
						stream_word, valid_chips, last_word);
					mismatches++;
				end else begin
					exp_word = expected_words.pop_front();
					checked++;
					if (stream_word !== exp_word.chips) begin
						$error("stream_word expected %h actual %h", exp_word.chips,
							stream_word);
						mismatches++;
					end
					if (valid_chips !== exp_word.count) begin
						$error("valid_chips expected %0d actual %0d", exp_word.count,
							valid_chips);
						mismatches++;
					end
					if (last_word !== exp_word.last) begin
						$error("last_word expected %b actual %b", exp_word.last, last_word);
						mismatches++;
					end
				end
			end
			pending_words = expected_words.size();
		end
	end

endmodule

@@ test/rts_remote_frame_encoder_core_test.sv @@
// Top of the remote frame encoder test: clock, reset, request stimulus, output
// stall pattern, watchdog and verdict.
// Depends on rfe_pkg, rts_remote_frame_encoder_core and rfe_stream_checker.
`timescale 1ns / 100ps

module rts_remote_frame_encoder_core_test;
	import rfe_pkg::*;

	localparam int FRAMES       = DEF_NUM_FRAMES;
	localparam int IDLE_LIMIT   = 3000;
	localparam int LONG_HOLD    = 500;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  remote_key;
	logic [23:0] device_address;
	logic [1:0]  command;
	logic [15:0] roll_code;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] stream_word;
	logic [6:0]  valid_chips;
	logic        last_word;

	int fail_count;
	int pending_words;
	int words_checked;
	int requests_sent;
	int idle_cycles;
	bit long_hold;
	bit quiet;

	rts_remote_frame_encoder_core #(.NUM_FRAMES(FRAMES)) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.remote_key     (remote_key),
		.device_address (device_address),
		.command        (command),
		.roll_code      (roll_code),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.stream_word    (stream_word),
		.valid_chips    (valid_chips),
		.last_word      (last_word)
	);

	rfe_stream_checker #(.NUM_FRAMES(FRAMES)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.remote_key     (remote_key),
		.device_address (device_address),
		.command        (command),
		.roll_code      (roll_code),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.stream_word    (stream_word),
		.valid_chips    (valid_chips),
		.last_word      (last_word),
		.fail_count     (fail_count),
		.pending_words  (pending_words),
		.words_checked  (words_checked)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Offer one request and hold it until it is taken
	task automatic send_request(input logic [7:0] key, input logic [23:0] addr,
			input logic [1:0] cmd, input logic [15:0] roll);
		@(negedge clk);
		in_valid       <= 1'b1;
		remote_key     <= key;
		device_address <= addr;
		command        <= cmd;
		roll_code      <= roll;
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	task automatic idle_input(input int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic send_random(input int gap_pct);
		send_request(8'($urandom), 24'($urandom), 2'($urandom), 16'($urandom));
		if (!quiet && $urandom_range(1, 100) <= gap_pct)
			idle_input($urandom_range(1, 11));
	endtask

	// Sender holds back until every predicted word has come out
	task automatic drain_output();
		idle_input(1);
		while (pending_words != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Output stall: random bursts, calm stretches, one long hold on request
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				out_stall <= 1'b0;
				long_hold = 1'b0;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else begin
				case ($urandom_range(0, 9))
					0, 1: begin
						out_stall <= 1'b1;
						repeat ($urandom_range(1, 11)) @(negedge clk);
						out_stall <= 1'b0;
					end
					2: begin
						out_stall <= 1'b0;
						repeat ($urandom_range(30, 80)) @(negedge clk);
					end
					default: out_stall <= 1'b0;
				endcase
			end
		end
	end

	// Watchdog on cycles with no word moving on either channel
	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("rts_remote_frame_encoder_core: mismatch");
		$finish;
	end

	// Stimulus and verdict
	initial begin
		in_valid       = 1'b0;
		remote_key     = '0;
		device_address = '0;
		command        = CMD_OFF;
		roll_code      = '0;
		long_hold      = 1'b0;
		quiet          = 1'b0;
		requests_sent  = 0;
		arst_n         = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed: field extremes, alternating bit patterns, every command
		send_request(8'h00, 24'h000000, CMD_OFF,  16'h0000);
		send_request(8'hFF, 24'hFFFFFF, CMD_ON,   16'hFFFF);
		send_request(8'h00, 24'hFFFFFF, CMD_PROG, 16'h0000);
		send_request(8'hFF, 24'h000000, CMD_MY,   16'hFFFF);
		idle_input(5);
		send_request(8'hAA, 24'h555555, CMD_OFF,  16'hAAAA);
		send_request(8'h55, 24'hAAAAAA, CMD_ON,   16'h5555);
		send_request(8'h01, 24'h000001, CMD_PROG, 16'h0001);
		send_request(8'h80, 24'h800000, CMD_MY,   16'h8000);
		send_request(8'h0F, 24'h0F0F0F, CMD_ON,   16'hF0F0);
		send_request(8'hF0, 24'hF0F0F0, CMD_OFF,  16'h0F0F);
		send_request(8'h7F, 24'h7FFFFF, CMD_MY,   16'h7FFF);
		send_request(8'hFE, 24'hFFFFFE, CMD_PROG, 16'hFFFE);
		drain_output();
		send_request(8'h12, 24'h345678, CMD_OFF,  16'h9ABC);
		send_request(8'h12, 24'h345678, CMD_ON,   16'h9ABC);
		send_request(8'h12, 24'h345678, CMD_PROG, 16'h9ABC);
		send_request(8'h12, 24'h345678, CMD_MY,   16'h9ABC);

		// Random with gaps
		repeat (120) send_random(30);

		// Receiver holds off while requests keep coming, then a full drain
		long_hold = 1'b1;
		repeat (8) send_random(0);
		drain_output();

		repeat (100) send_random(30);

		// Closing stretch with no idling on either side
		quiet = 1'b1;
		repeat (40) send_random(0);
		idle_input(1);

		while (pending_words != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d requests across all four commands, %0d words checked,",
			requests_sent, words_checked);
		$display("with field extremes, a long output hold and a mid-run drain.");
		if (fail_count == 0 && pending_words == 0)
			$display("rts_remote_frame_encoder_core: match");
		else
			$display("rts_remote_frame_encoder_core: mismatch");
		$finish;
	end

endmodule
